@@ rtl/utf8d_pkg.sv @@
// shared types and constants of the utf-8 stream decoder
package utf8d_pkg;

  localparam int unsigned UnitW     = 21;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [UnitW-1:0] MaxCode   = 21'h10FFFF;
  localparam logic [UnitW-1:0] SurrHi    = 21'h00D800;
  localparam logic [UnitW-1:0] SurrLo    = 21'h00DC00;
  localparam logic [UnitW-1:0] SurrEnd   = 21'h00DFFF;
  localparam logic [UnitW-1:0] BmpMax    = 21'h00FFFF;
  localparam logic [UnitW-1:0] SuppBase  = 21'h010000;
  localparam logic [UnitW-1:0] ReplChar  = 21'h00003F;

  localparam logic [2:0] PaddrW = 3'd3;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusSubst = 2'd1,
    StatusFail  = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    RegStrict = 1'b0,
    RegUtf16  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic strict_mode;
    logic utf16_units;
  } cfg_t;

  typedef struct packed {
    logic [UnitW-1:0] unit;
    logic             has_unit;
    logic             run_last;
    logic             string_done;
    logic [1:0]       status;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

@@ rtl/utf8d_if.sv @@
// stream interfaces for input bytes and decoded units
interface utf8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       string_last;

  modport source (output valid, output byte_value, output string_last, input ready);
  modport sink (input valid, input byte_value, input string_last, output ready);
endinterface

interface utf8d_unit_if;
  logic                        valid;
  logic                        ready;
  logic [utf8d_pkg::UnitW-1:0] unit;
  logic                        has_unit;
  logic                        run_last;
  logic                        string_done;
  logic [1:0]                  status;

  modport source (output valid, output unit, output has_unit, output run_last,
                  output string_done, output status, input ready);
  modport sink (input valid, input unit, input has_unit, input run_last,
                input string_done, input status, output ready);
endinterface

@@ rtl/utf8d_cfg.sv @@
// apb configuration registers of the decoder
module utf8d_cfg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output utf8d_pkg::cfg_t       cfg_o
);

  utf8d_pkg::cfg_t   cfg_q, cfg_d;
  utf8d_pkg::reg_idx_e idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = utf8d_pkg::reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        utf8d_pkg::RegStrict: cfg_d.strict_mode = pwdata[0];
        utf8d_pkg::RegUtf16:  cfg_d.utf16_units = pwdata[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      utf8d_pkg::RegStrict: prdata = {31'd0, cfg_q.strict_mode};
      utf8d_pkg::RegUtf16:  prdata = {31'd0, cfg_q.utf16_units};
      default:              prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/utf8d_core.sv @@
// input register, decode state and per-byte decode logic
module utf8d_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  utf8d_pkg::cfg_t      cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           in_byte_i,
  input  logic                 in_last_i,
  input  logic                 room_i,
  output utf8d_pkg::push_t     push_o
);

  logic                        valid_q;
  logic [7:0]                  byte_q;
  logic                        last_q;
  logic                        advance;

  logic [utf8d_pkg::UnitW-1:0] partial_q, partial_d;
  logic [1:0]                  pending_q, pending_d;
  logic                        subst_q, subst_d;
  logic                        abort_q, abort_d;

  logic                        complete;
  logic                        abort_now;
  logic                        subst_now;
  logic [utf8d_pkg::UnitW-1:0] code;
  logic [utf8d_pkg::UnitW-1:0] v;
  logic [1:0]                  n;
  utf8d_pkg::result_t          r0, r1;
  logic [1:0]                  status;

  assign advance    = valid_q && room_i;
  assign in_ready_o = !valid_q || room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
      last_q <= in_last_i;
    end
  end

  // decode of one byte
  always_comb begin
    partial_d = partial_q;
    pending_d = pending_q;
    subst_d   = subst_q;
    abort_d   = abort_q;
    complete  = 1'b0;
    code      = '0;
    if (!abort_q) begin
      if (pending_q == 2'd0) begin
        priority if (byte_q <= 8'h7F) begin
          code     = {13'd0, byte_q};
          complete = 1'b1;
        end else if (byte_q <= 8'hBF) begin
          if (cfg_i.strict_mode) begin
            abort_d = 1'b1;
          end else begin
            code     = utf8d_pkg::ReplChar;
            subst_d  = 1'b1;
            complete = 1'b1;
          end
        end else if (byte_q <= 8'hDF) begin
          partial_d = {16'd0, byte_q[4:0]};
          pending_d = 2'd1;
        end else if (byte_q <= 8'hEF) begin
          partial_d = {17'd0, byte_q[3:0]};
          pending_d = 2'd2;
        end else if (byte_q <= 8'hF7) begin
          partial_d = {18'd0, byte_q[2:0]};
          pending_d = 2'd3;
        end else begin
          abort_d = 1'b1;
        end
      end else begin
        if (byte_q[7:6] != 2'b10) begin
          abort_d = 1'b1;
        end else begin
          partial_d = {partial_q[14:0], byte_q[5:0]};
          pending_d = pending_q - 2'd1;
          if (pending_d == 2'd0) begin
            code     = partial_d;
            complete = 1'b1;
          end
        end
      end

      if (!abort_d && !complete && last_q && pending_d != 2'd0) begin
        if (cfg_i.strict_mode) begin
          abort_d = 1'b1;
        end else begin
          code     = utf8d_pkg::ReplChar;
          subst_d  = 1'b1;
          complete = 1'b1;
        end
      end

      if (!abort_d && complete && code > utf8d_pkg::MaxCode) begin
        if (cfg_i.strict_mode) begin
          abort_d = 1'b1;
        end else begin
          code    = utf8d_pkg::ReplChar;
          subst_d = 1'b1;
        end
      end

      if (!abort_d && complete && cfg_i.utf16_units &&
          code >= utf8d_pkg::SurrHi && code <= utf8d_pkg::SurrEnd) begin
        abort_d = 1'b1;
      end

      if (abort_d || complete) begin
        partial_d = '0;
        pending_d = 2'd0;
      end
      if (abort_d) begin
        complete = 1'b0;
      end
    end

    // string status before the end-of-string clear
    abort_now = abort_d;
    subst_now = subst_d;

    if (last_q) begin
      partial_d = '0;
      pending_d = 2'd0;
      subst_d   = 1'b0;
      abort_d   = 1'b0;
    end
  end

  // result assembly, surrogate split in utf-16 mode
  always_comb begin
    v  = code - utf8d_pkg::SuppBase;
    r0 = '0;
    r1 = '0;
    n  = 2'd0;
    status = abort_now ? utf8d_pkg::StatusFail :
             (subst_now ? utf8d_pkg::StatusSubst : utf8d_pkg::StatusOk);
    if (complete) begin
      if (cfg_i.utf16_units && code > utf8d_pkg::BmpMax) begin
        n        = 2'd2;
        r0.unit  = utf8d_pkg::SurrHi + {11'd0, v[19:10]};
        r1.unit  = utf8d_pkg::SurrLo + {11'd0, v[9:0]};
        r0.has_unit = 1'b1;
        r1.has_unit = 1'b1;
      end else begin
        n        = 2'd1;
        r0.unit  = code;
        r0.has_unit = 1'b1;
      end
    end else if (last_q) begin
      n = 2'd1;
    end
    if (n == 2'd2) begin
      r1.run_last    = 1'b1;
      r1.string_done = last_q;
      r1.status      = last_q ? status : 2'd0;
    end else begin
      r0.run_last    = 1'b1;
      r0.string_done = last_q;
      r0.status      = last_q ? status : 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      pending_q <= 2'd0;
      subst_q   <= 1'b0;
      abort_q   <= 1'b0;
    end else if (advance) begin
      partial_q <= partial_d;
      pending_q <= pending_d;
      subst_q   <= subst_d;
      abort_q   <= abort_d;
    end
  end

  assign push_o.n  = advance ? n : 2'd0;
  assign push_o.r0 = r0;
  assign push_o.r1 = r1;

  a_last_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && last_q |-> n != 2'd0)
    else $error("end of string gave no result");

  a_abort_no_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && abort_q |-> n == {1'b0, last_q} && !r0.has_unit)
    else $error("unit produced after abort");

  a_idle_state_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && last_q |=> pending_q == 2'd0 && !abort_q && !subst_q)
    else $error("state not cleared at end of string");

endmodule

@@ rtl/utf8d_fifo.sv @@
// result queue, takes up to two results per cycle and delivers one per cycle while the sink is ready
module utf8d_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  utf8d_pkg::push_t    push_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output utf8d_pkg::result_t  out_data_o
);

  utf8d_pkg::result_t                mem_q [utf8d_pkg::FifoDepth];
  logic [utf8d_pkg::FifoPtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [utf8d_pkg::FifoCntW-1:0]   cnt_q, cnt_d;
  logic                             pop;
  logic [utf8d_pkg::FifoPtrW-1:0]   wr_nx;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rd_q];
  assign room_o      = cnt_q <= utf8d_pkg::FifoCntW'(utf8d_pkg::FifoDepth - 2);
  assign wr_nx       = wr_q + utf8d_pkg::FifoPtrW'(1);

  assign wr_d  = wr_q + utf8d_pkg::FifoPtrW'(push_i.n);
  assign rd_d  = rd_q + utf8d_pkg::FifoPtrW'(pop);
  assign cnt_d = cnt_q + utf8d_pkg::FifoCntW'(push_i.n) - utf8d_pkg::FifoCntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_nx] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= utf8d_pkg::FifoCntW'(utf8d_pkg::FifoDepth))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.n != 2'd0 |-> room_o)
    else $error("push without room");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != '0 || push_i.n == 2'd0 |-> 1'b1 ##0
    (wr_q - rd_q) == utf8d_pkg::FifoPtrW'(cnt_q) ||
    cnt_q == utf8d_pkg::FifoCntW'(utf8d_pkg::FifoDepth))
    else $error("queue pointers and count disagree");

endmodule

@@ rtl/utf8_stream_decoder.sv @@
// utf-8 stream decoder top level
// path: an accepted byte is held in the core input register, decoded, and its results go through the result queue
// throughput: one byte per cycle while the result queue has room; a byte that gives a surrogate pair
// puts two results into the queue, bounded by the one-result-per-cycle output queue
// reset: rst_ni clears decode state, the result queue and both config registers
module utf8_stream_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  utf8d_byte_if.sink         byte_i,
  utf8d_unit_if.source       unit_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  utf8d_pkg::cfg_t    cfg;
  utf8d_pkg::push_t   push;
  utf8d_pkg::result_t res;
  logic               room;

  utf8d_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  utf8d_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (byte_i.valid),
    .in_ready_o (byte_i.ready),
    .in_byte_i  (byte_i.byte_value),
    .in_last_i  (byte_i.string_last),
    .room_i     (room),
    .push_o     (push)
  );

  utf8d_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (unit_o.valid),
    .out_ready_i (unit_o.ready),
    .out_data_o  (res)
  );

  assign unit_o.unit        = res.unit;
  assign unit_o.has_unit    = res.has_unit;
  assign unit_o.run_last    = res.run_last;
  assign unit_o.string_done = res.string_done;
  assign unit_o.status      = res.status;

endmodule

@@ test/tb_top.sv @@
// testbench for the utf-8 stream decoder: directed table, then random strings
`timescale 1ns / 100ps

module tb_top;
  import utf8d_pkg::*;

  localparam int unsigned CycleLimit   = 200_000;
  localparam int unsigned NumDirRows   = 23;
  localparam int unsigned NumPhases    = 6;
  localparam int unsigned PhaseBytes   = 210;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned HoldCycles   = 400;

  localparam cfg_t CfgPlain    = '{strict_mode: 1'b0, utf16_units: 1'b0};
  localparam cfg_t CfgStrict   = '{strict_mode: 1'b1, utf16_units: 1'b0};
  localparam cfg_t CfgUtf16    = '{strict_mode: 1'b0, utf16_units: 1'b1};
  localparam cfg_t CfgStrict16 = '{strict_mode: 1'b1, utf16_units: 1'b1};

  typedef struct packed {
    cfg_t             cfg;
    logic [7:0]       byte_val;
    logic             last;
    logic             typed;
    logic             has;
    logic [UnitW-1:0] unit;
    status_e          st;
  } dir_row_t;

  localparam dir_row_t DirRows [NumDirRows] = '{
    '{CfgPlain,    8'h00, 1'b1, 1'b1, 1'b1, 21'h00, StatusOk},
    '{CfgPlain,    8'h7F, 1'b1, 1'b1, 1'b1, 21'h7F, StatusOk},
    '{CfgPlain,    8'h80, 1'b1, 1'b1, 1'b1, 21'h3F, StatusSubst},
    '{CfgPlain,    8'hFF, 1'b1, 1'b1, 1'b0, 21'h00, StatusFail},
    '{CfgPlain,    8'hC3, 1'b0, 1'b0, 1'b0, 21'h00, StatusOk},
    '{CfgPlain,    8'hA9, 1'b1, 1'b0, 1'b0, 21'h00, StatusOk},
    '{CfgPlain,    8'hF7, 1'b0, 1'b0, 1'b0, 21'h00, StatusOk},
    '{CfgPlain,    8'hBF, 1'b0, 1'b0, 1'b0, 21'h00, StatusOk},
    '{CfgPlain,    8'hBF, 1'b0, 1'b0, 1'b0, 21'h00, StatusOk},
    '{CfgPlain,    8'hBF, 1'b1, 1'b1, 1'b1, 21'h3F, StatusSubst},
    '{CfgPlain,    8'hC3, 1'b1, 1'b1, 1'b1, 21'h3F, StatusSubst},
    '{CfgPlain,    8'hF8, 1'b0, 1'b0, 1'b0, 21'h00, StatusOk},
    '{CfgPlain,    8'h41, 1'b1, 1'b1, 1'b0, 21'h00, StatusFail},
    '{CfgPlain,    8'hC3, 1'b0, 1'b0, 1'b0, 21'h00, StatusOk},
    '{CfgPlain,    8'h41, 1'b1, 1'b1, 1'b0, 21'h00, StatusFail},
    '{CfgStrict16, 8'h80, 1'b1, 1'b1, 1'b0, 21'h00, StatusFail},
    '{CfgStrict16, 8'hF4, 1'b0, 1'b0, 1'b0, 21'h00, StatusOk},
    '{CfgStrict16, 8'h8F, 1'b0, 1'b0, 1'b0, 21'h00, StatusOk},
    '{CfgStrict16, 8'hBF, 1'b0, 1'b0, 1'b0, 21'h00, StatusOk},
    '{CfgStrict16, 8'hBF, 1'b1, 1'b0, 1'b0, 21'h00, StatusOk},
    '{CfgStrict16, 8'hED, 1'b0, 1'b0, 1'b0, 21'h00, StatusOk},
    '{CfgStrict16, 8'hA0, 1'b0, 1'b0, 1'b0, 21'h00, StatusOk},
    '{CfgStrict16, 8'h80, 1'b1, 1'b1, 1'b0, 21'h00, StatusFail}
  };

  localparam cfg_t PhaseCfg [NumPhases] = '{
    CfgPlain, CfgStrict16, CfgUtf16, CfgStrict, CfgStrict16, CfgPlain
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  utf8d_byte_if byte_bus ();
  utf8d_unit_if unit_bus ();

  utf8_stream_decoder u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_bus),
    .unit_o  (unit_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  cfg_t             cfg;
  bit               cfg_loaded = 1'b0;
  logic [UnitW-1:0] dec_code;
  logic [1:0]       dec_pend;
  logic             dec_subst;
  logic             dec_abort;

  result_t     units_due [$];
  int unsigned err_cnt       = 0;
  int unsigned bytes_sent    = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned src_idle      = 32;
  int unsigned snk_idle      = 82;
  int unsigned hold_request  = 0;
  int unsigned hold_left     = 0;

  function automatic int decode_byte(input logic [7:0] b, input logic last,
                                     output result_t r0, output result_t r1);
    logic [UnitW-1:0] code;
    logic [UnitW-1:0] v;
    logic             complete;
    status_e          st;
    int               n;
    code     = '0;
    complete = 1'b0;
    n        = 0;
    r0       = '0;
    r1       = '0;
    if (!dec_abort) begin
      if (dec_pend == 2'd0) begin
        if (b <= 8'h7F) begin
          code     = {13'd0, b};
          complete = 1'b1;
        end else if (b <= 8'hBF) begin
          if (cfg.strict_mode) begin
            dec_abort = 1'b1;
          end else begin
            code      = ReplChar;
            dec_subst = 1'b1;
            complete  = 1'b1;
          end
        end else if (b <= 8'hDF) begin
          dec_code = {16'd0, b[4:0]};
          dec_pend = 2'd1;
        end else if (b <= 8'hEF) begin
          dec_code = {17'd0, b[3:0]};
          dec_pend = 2'd2;
        end else if (b <= 8'hF7) begin
          dec_code = {18'd0, b[2:0]};
          dec_pend = 2'd3;
        end else begin
          dec_abort = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        dec_abort = 1'b1;
      end else begin
        dec_code = {dec_code[UnitW-7:0], b[5:0]};
        dec_pend = dec_pend - 2'd1;
        if (dec_pend == 2'd0) begin
          code     = dec_code;
          complete = 1'b1;
        end
      end

      // truncated sequence at the string end
      if (!dec_abort && !complete && last && dec_pend != 2'd0) begin
        if (cfg.strict_mode) begin
          dec_abort = 1'b1;
        end else begin
          code      = ReplChar;
          dec_subst = 1'b1;
          complete  = 1'b1;
        end
      end
      if (!dec_abort && complete && code > MaxCode) begin
        if (cfg.strict_mode) begin
          dec_abort = 1'b1;
        end else begin
          code      = ReplChar;
          dec_subst = 1'b1;
        end
      end
      if (!dec_abort && complete && cfg.utf16_units && code >= SurrHi && code <= SurrEnd) begin
        dec_abort = 1'b1;
      end
      if (dec_abort) begin
        dec_code = '0;
        dec_pend = 2'd0;
        complete = 1'b0;
      end
      if (complete) begin
        dec_code = '0;
        dec_pend = 2'd0;
        if (cfg.utf16_units && code > BmpMax) begin
          v           = code - SuppBase;
          r0.unit     = (v >> 10) + SurrHi;
          r0.has_unit = 1'b1;
          r1.unit     = (v & 21'h3FF) + SurrLo;
          r1.has_unit = 1'b1;
          n           = 2;
        end else begin
          r0.unit     = code;
          r0.has_unit = 1'b1;
          n           = 1;
        end
      end
    end

    if (last) begin
      if (n == 0) begin
        n = 1;
      end
      st = dec_abort ? StatusFail : (dec_subst ? StatusSubst : StatusOk);
      if (n == 1) begin
        r0.string_done = 1'b1;
        r0.status      = st;
      end else begin
        r1.string_done = 1'b1;
        r1.status      = st;
      end
      dec_code  = '0;
      dec_pend  = 2'd0;
      dec_subst = 1'b0;
      dec_abort = 1'b0;
    end

    if (n == 1) begin
      r0.run_last = 1'b1;
    end else if (n == 2) begin
      r1.run_last = 1'b1;
    end
    return n;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic last,
                           input logic use_typed, input result_t typed_res);
    result_t r0;
    result_t r1;
    int      n;
    while ($urandom_range(0, 99) < src_idle) begin
      byte_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_bus.valid       <= 1'b1;
    byte_bus.byte_value  <= b;
    byte_bus.string_last <= last;
    do @(posedge clk_i); while (!byte_bus.ready);
    bytes_sent++;
    n = decode_byte(b, last, r0, r1);
    if (use_typed) begin
      units_due.push_back(typed_res);
    end else begin
      if (n >= 1) units_due.push_back(r0);
      if (n == 2) units_due.push_back(r1);
    end
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {31'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_config(input cfg_t c);
    byte_bus.valid <= 1'b0;
    while (units_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    write_reg(RegStrict, c.strict_mode);
    write_reg(RegUtf16, c.utf16_units);
    cfg        = c;
    cfg_loaded = 1'b1;
  endtask

  task automatic send_random_string();
    logic [7:0]       bytes_q [$];
    logic [7:0]       enc [4];
    logic [UnitW-1:0] cp;
    int               nchar;
    int               kind;
    int               len;
    int               keep;
    nchar = int'($urandom_range(1, 6));
    for (int i = 0; i < nchar; i++) begin
      kind = int'($urandom_range(0, 99));
      if (kind < 12) begin
        bytes_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        len = int'($urandom_range(1, 4));
        case (len)
          1: begin
            cp     = UnitW'($urandom_range(0, 'h7F));
            enc[0] = cp[7:0];
          end
          2: begin
            cp     = UnitW'($urandom_range(0, 'h7FF));
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
          end
          3: begin
            cp     = UnitW'($urandom_range(0, 'hFFFF));
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
          end
          default: begin
            if ($urandom_range(0, 9) == 0) cp = UnitW'($urandom_range(0, 'h1FFFFF));
            else cp = UnitW'($urandom_range('h10000, 'h10FFFF));
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
          end
        endcase
        // broken sequence: drop trailing continuation bytes
        keep = (kind < 20 && len > 1) ? int'($urandom_range(1, len - 1)) : len;
        for (int k = 0; k < keep; k++) begin
          bytes_q.push_back(enc[k]);
        end
      end
    end
    for (int i = 0; i < bytes_q.size(); i++) begin
      push_byte(bytes_q[i], i == bytes_q.size() - 1, 1'b0, '0);
    end
  endtask

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    err_cnt++;
    $display("%0t mismatch %s: expected %h, got %h", $time, name, want, got);
  endtask

  // sink side: check every accepted word and drive ready
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (unit_bus.valid && unit_bus.ready) begin
        got = '{unit: unit_bus.unit, has_unit: unit_bus.has_unit,
                run_last: unit_bus.run_last, string_done: unit_bus.string_done,
                status: unit_bus.status};
        if (units_due.size() == 0) begin
          err_cnt++;
          $display("%0t unexpected word: expected none, got %h", $time, got);
        end else begin
          want = units_due.pop_front();
          if (got.unit !== want.unit)
            report_field("unit", 32'(want.unit), 32'(got.unit));
          if (got.has_unit !== want.has_unit)
            report_field("has_unit", 32'(want.has_unit), 32'(got.has_unit));
          if (got.run_last !== want.run_last)
            report_field("run_last", 32'(want.run_last), 32'(got.run_last));
          if (got.string_done !== want.string_done)
            report_field("string_done", 32'(want.string_done), 32'(got.string_done));
          if (got.status !== want.status)
            report_field("status", 32'(want.status), 32'(got.status));
        end
      end
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        unit_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        unit_bus.ready <= ($urandom_range(0, 99) >= snk_idle);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned phase_start;
    rst_ni               = 1'b0;
    byte_bus.valid       = 1'b0;
    byte_bus.byte_value  = 8'h00;
    byte_bus.string_last = 1'b0;
    unit_bus.ready       = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    cfg                  = CfgPlain;
    dec_code             = '0;
    dec_pend             = 2'd0;
    dec_subst            = 1'b0;
    dec_abort            = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirRows; i++) begin
      if (!cfg_loaded || DirRows[i].cfg != cfg) apply_config(DirRows[i].cfg);
      push_byte(DirRows[i].byte_val, DirRows[i].last, DirRows[i].typed,
                '{unit: DirRows[i].unit, has_unit: DirRows[i].has, run_last: 1'b1,
                  string_done: DirRows[i].last, status: DirRows[i].st});
    end

    for (int p = 0; p < NumPhases; p++) begin
      apply_config(PhaseCfg[p]);
      if (p < 2) begin
        src_idle = 32;
        snk_idle = 82;
      end else if (p < 4) begin
        src_idle = 82;
        snk_idle = 32;
      end else begin
        src_idle = 0;
        snk_idle = 0;
      end
      // long sink stall while bytes keep coming, fills the result queue
      if (p == 4) hold_request = HoldCycles;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) send_random_string();
    end

    byte_bus.valid <= 1'b0;
    while (units_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
